// File: sv/tpli_pkg.sv
// Shared types and constants for the timeline playhead loop indexer.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps
package tpli_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = 10;
  localparam int TimeW      = 32;
  localparam int FracW      = 8;
  localparam int QTimeW     = TimeW + FracW;   // playhead in Q.8
  localparam int SumW       = 44;              // signed playhead plus move
  localparam int DivW       = 48;              // divider operand width

  // Configuration register indexes.
  localparam logic [2:0] REG_SPEED       = 3'd0;
  localparam logic [2:0] REG_LOOP_MODE   = 3'd1;
  localparam logic [2:0] REG_LOOP_ENABLE = 3'd2;
  localparam logic [2:0] REG_LOOP_START  = 3'd3;
  localparam logic [2:0] REG_LOOP_END    = 3'd4;
  localparam logic [2:0] REG_RUN_ENABLE  = 3'd5;
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd6;

  // Loop modes.
  localparam logic [1:0] MODE_WRAP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  // Request codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SKIP, S_RDL, S_MUL, S_ADD, S_LOOP, S_DIV1, S_LFIN,
    S_SCAN0, S_SCAN, S_RDI, S_RDN, S_INT, S_INT2, S_DIV2, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_WRITE, CMD_ACCEPT, CMD_RD_LAST, CMD_MUL, CMD_ADD,
    CMD_LOOP, CMD_LOOP_FIN, CMD_SCAN_START, CMD_SCAN, CMD_RD_IDX,
    CMD_RD_NXT, CMD_INTERP, CMD_INTERP_START, CMD_EMIT, CMD_EMIT_HELD
  } dp_cmd_t;

  typedef struct packed {
    logic skip;      // stopped or empty table
    logic need_div;  // loop step needs the divider
    logic found;     // frame search finished
    logic eq;        // neighbor times are equal
    logic div_done;  // divider result ready
  } dp_status_t;

endpackage

// File: sv/tpli_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tpli_pkg for the operand width.
`timescale 1ns / 1ps
module tpli_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tpli_pkg::DivW-1:0] dividend,
  input  logic [tpli_pkg::DivW-1:0] divisor,
  output logic                      done,
  output logic [tpli_pkg::DivW-1:0] quot,
  output logic [tpli_pkg::DivW-1:0] rem
);
  import tpli_pkg::*;

  localparam int CntW = $clog2(DivW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DivW - 1);

  logic [DivW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;

  // Trial subtraction of the shifted partial remainder.
  assign shifted = {rem, quot[DivW-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quot <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[DivW]) begin
          rem  <= diff[DivW-1:0];
          quot <= {quot[DivW-2:0], 1'b1};
        end else begin
          rem  <= shifted[DivW-1:0];
          quot <= {quot[DivW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/tpli_ctrl.sv
// Controller state machine for the playhead indexer.
// Depends on tpli_pkg for the state, command and status types.
`timescale 1ns / 1ps
module tpli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 op,
  input  tpli_pkg::dp_status_t status,
  output tpli_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import tpli_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && op == OP_TICK) begin
          state_next = status.skip ? S_SKIP : S_RDL;
        end
      end
      S_SKIP:  state_next = S_IDLE;
      S_RDL:   state_next = S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_LOOP;
      S_LOOP:  state_next = status.need_div ? S_DIV1 : S_SCAN0;
      S_DIV1:  if (status.div_done) state_next = S_LFIN;
      S_LFIN:  state_next = S_SCAN0;
      S_SCAN0: state_next = S_SCAN;
      S_SCAN:  if (status.found) state_next = S_RDI;
      S_RDI:   state_next = S_RDN;
      S_RDN:   state_next = S_INT;
      S_INT:   state_next = S_INT2;
      S_INT2:  state_next = status.eq ? S_EMIT : S_DIV2;
      S_DIV2:  if (status.div_done) state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start && op == OP_WRITE) begin
          cmd = CMD_WRITE;
        end else if (start && !status.skip) begin
          cmd = CMD_ACCEPT;
        end
      end
      S_SKIP:  cmd = CMD_EMIT_HELD;
      S_RDL:   cmd = CMD_RD_LAST;
      S_MUL:   cmd = CMD_MUL;
      S_ADD:   cmd = CMD_ADD;
      S_LOOP:  cmd = CMD_LOOP;
      S_LFIN:  cmd = CMD_LOOP_FIN;
      S_SCAN0: cmd = CMD_SCAN_START;
      S_SCAN:  cmd = status.found ? CMD_NONE : CMD_SCAN;
      S_RDI:   cmd = CMD_RD_IDX;
      S_RDN:   cmd = CMD_RD_NXT;
      S_INT:   cmd = CMD_INTERP;
      S_INT2:  cmd = CMD_INTERP_START;
      S_EMIT:  cmd = CMD_EMIT;
      default: cmd = CMD_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

// File: sv/tpli_datapath.sv
// Datapath: configuration, timestamp memory, playhead arithmetic and search.
// Depends on tpli_pkg and instantiates tpli_div.
`timescale 1ns / 1ps
module tpli_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tpli_pkg::dp_cmd_t           cmd,
  output tpli_pkg::dp_status_t        status,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic [19:0]                 elapsed_us,
  input  logic [tpli_pkg::AddrW-1:0]  entry_index,
  input  logic [tpli_pkg::TimeW-1:0]  entry_time,
  output logic                        done,
  output logic [tpli_pkg::AddrW-1:0]  frame_index,
  output logic [tpli_pkg::AddrW-1:0]  next_index,
  output logic [17:0]                 interp_index,
  output logic                        frame_new,
  output logic [tpli_pkg::TimeW-1:0]  playhead_time,
  output logic                        moving_forward
);
  import tpli_pkg::*;

  localparam int InterpMax = 262143;

  // Configuration registers.
  logic signed [15:0] speed;
  logic [1:0]         loop_mode;
  logic               loop_enable;
  logic [TimeW-1:0]   loop_start, loop_end;
  logic               run_enable;
  logic [10:0]        entry_count;

  // Timestamp memory.
  logic [TimeW-1:0] mem [TableDepth];
  logic [AddrW-1:0] rd_addr;
  logic [TimeW-1:0] rd_data;

  // Tick state and work registers.
  logic [19:0]              el;
  logic signed [41:0]       playhead;
  logic                     dir;
  logic                     first_tick;
  logic [10:0]              prev_frame;
  logic [TimeW-1:0]         t0, tl, ti, tn;
  logic signed [36:0]       prod;
  logic signed [SumW-1:0]   t;
  logic                     inc;
  logic [QTimeW-1:0]        lo, hi;
  logic [QTimeW-1:0]        d;
  logic                     t_neg;
  logic                     q_neg;
  logic [AddrW-1:0]         idx, nxt, scan_addr;
  logic                     found;
  logic [AddrW-1:0]         held_frame, held_next;
  logic [17:0]              held_interp;

  // Combinational helpers.
  logic [10:0]              size;
  logic [AddrW-1:0]         last;
  logic signed [SumW-1:0]   tq0, tql, tqr, lo_s, hi_s, delta, t_sum;
  logic [TimeW-1:0]         a_raw, b_raw, a_sw, b_sw;
  logic signed [SumW-1:0]   t_lo, over;
  logic                     outside;
  logic                     need_div;
  logic [AddrW-1:0]         nxt_calc;
  logic signed [SumW-1:0]   num;
  logic signed [TimeW:0]    den0, den;
  logic                     eq;
  logic                     div_start, div_done;
  logic [DivW-1:0]          div_a, div_b, quot, rem;
  logic [QTimeW-1:0]        wrap_r;
  logic [QTimeW:0]          pp_over;
  logic                     pp_dir;
  logic signed [DivW+1:0]   qs, v;
  logic [17:0]              v_sat;

  assign size = (entry_count > 11'(TableDepth)) ? 11'(TableDepth) : entry_count;
  assign last = AddrW'(size - 11'd1);

  assign tq0  = SumW'({t0, 8'b0});
  assign tql  = SumW'({tl, 8'b0});
  assign tqr  = SumW'({rd_data, 8'b0});
  assign lo_s = SumW'(lo);
  assign hi_s = SumW'(hi);

  // Move and loop range.
  assign delta = dir ? SumW'(prod) : -SumW'(prod);
  assign t_sum = SumW'(playhead) + delta;
  assign a_raw = loop_enable ? loop_start : t0;
  assign b_raw = loop_enable ? loop_end : tl;
  assign a_sw  = (b_raw < a_raw) ? b_raw : a_raw;
  assign b_sw  = (b_raw < a_raw) ? a_raw : b_raw;

  // Loop step decisions.
  assign t_lo    = t - lo_s;
  assign outside = (t < lo_s) || (t > hi_s);
  assign over    = (t > hi_s) ? (t - hi_s) : (lo_s - t);
  assign need_div = (d != '0) && ((loop_mode == MODE_WRAP) ||
                    (loop_mode == MODE_PINGPONG && outside));

  // Neighbor index in the direction of travel.
  always_comb begin
    nxt_calc = idx;
    if (inc) begin
      if (idx < last) nxt_calc = idx + 1'b1;
    end else begin
      if (idx != '0) nxt_calc = idx - 1'b1;
    end
  end

  // Interpolation operands.
  assign num  = t - SumW'({ti, 8'b0});
  assign den0 = $signed({1'b0, tn}) - $signed({1'b0, ti});
  assign den  = (nxt < idx) ? -den0 : den0;
  assign eq   = (ti == tn);

  // Divider operand selection; the divider is shared by loop and interpolation.
  always_comb begin
    div_a = '0;
    div_b = '0;
    if (cmd == CMD_LOOP) begin
      div_b = DivW'(d);
      if (loop_mode == MODE_WRAP) begin
        div_a = t_lo[SumW-1] ? DivW'(-t_lo) : DivW'(t_lo);
      end else begin
        div_a = DivW'(over - SumW'(1));
      end
    end else begin
      div_a = num[SumW-1] ? DivW'(-num) : DivW'(num);
      div_b = den[TimeW] ? DivW'(-den) : DivW'(den);
    end
  end

  assign div_start = ((cmd == CMD_LOOP) && need_div) ||
                     ((cmd == CMD_INTERP_START) && !eq);

  tpli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // Loop finishing values from the divider.
  assign wrap_r  = (t_neg && rem != '0) ? (d - QTimeW'(rem)) : QTimeW'(rem);
  assign pp_over = (QTimeW + 1)'(rem) + 1'b1;
  assign pp_dir  = dir ^ quot[0];

  // Floor quotient and saturated interpolated index.
  assign qs = q_neg ? (-$signed({2'b0, quot}) - ((rem != '0) ? 1 : 0))
                    : $signed({2'b0, quot});
  assign v  = $signed((DivW + 2)'({idx, 8'b0})) + (eq ? '0 : qs);
  always_comb begin
    if (v < 0) begin
      v_sat = '0;
    end else if (v > InterpMax) begin
      v_sat = 18'(InterpMax);
    end else begin
      v_sat = v[17:0];
    end
  end

  // Memory read address by command.
  always_comb begin
    unique case (cmd)
      CMD_RD_LAST:    rd_addr = last;
      CMD_SCAN_START: rd_addr = inc ? AddrW'(1) : last - 1'b1;
      CMD_SCAN:       rd_addr = inc ? scan_addr + 1'b1 : scan_addr - 1'b1;
      CMD_RD_IDX:     rd_addr = idx;
      CMD_RD_NXT:     rd_addr = nxt;
      default:        rd_addr = '0;
    endcase
  end

  // Timestamp memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd == CMD_WRITE) begin
      mem[entry_index] <= entry_time;
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration registers, tick state and work registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed          <= 16'sd256;
      loop_mode      <= '0;
      loop_enable    <= 1'b0;
      loop_start     <= '0;
      loop_end       <= '0;
      run_enable     <= 1'b0;
      entry_count    <= '0;
      playhead       <= -42'sd1;
      dir            <= 1'b1;
      first_tick     <= 1'b1;
      prev_frame     <= '1;
      found          <= 1'b0;
      held_frame     <= '0;
      held_next      <= '0;
      held_interp    <= '0;
      done           <= 1'b0;
      frame_new      <= 1'b0;
      frame_index    <= '0;
      next_index     <= '0;
      interp_index   <= '0;
      playhead_time  <= '0;
      moving_forward <= 1'b1;
    end else begin
      done      <= 1'b0;
      frame_new <= 1'b0;

      // Register writes; choosing ping-pong resets direction from speed.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPEED:       speed <= $signed(cfg_data[15:0]);
          REG_LOOP_MODE: begin
            loop_mode <= cfg_data[1:0];
            if (cfg_data[1:0] == MODE_PINGPONG) dir <= (speed > 0);
          end
          REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
          REG_LOOP_START:  loop_start <= cfg_data;
          REG_LOOP_END:    loop_end <= cfg_data;
          REG_RUN_ENABLE:  run_enable <= cfg_data[0];
          REG_ENTRY_COUNT: entry_count <= cfg_data[10:0];
          default: ;
        endcase
      end

      unique case (cmd)
        CMD_ACCEPT: begin
          el    <= first_tick ? '0 : elapsed_us;
          found <= 1'b0;
        end
        CMD_RD_LAST: begin
          // First tick places an unset playhead at the first table time.
          t0 <= rd_data;
          if (first_tick) begin
            if (playhead < 0) playhead <= 42'($signed({2'b0, rd_data, 8'b0}));
            prev_frame <= '1;
            first_tick <= 1'b0;
          end
        end
        CMD_MUL: begin
          tl   <= rd_data;
          prod <= speed * $signed({1'b0, el});
        end
        CMD_ADD: begin
          t   <= t_sum;
          inc <= (delta > 0);
          lo  <= {a_sw, 8'b0};
          hi  <= {b_sw, 8'b0};
          d   <= {b_sw, 8'b0} - {a_sw, 8'b0};
        end
        CMD_LOOP: begin
          t_neg <= t_lo[SumW-1];
          if (loop_mode == MODE_WRAP) begin
            if (d == '0) t <= hi_s;
          end else if (loop_mode == MODE_PINGPONG) begin
            if (outside && d == '0) begin
              t   <= dir ? hi_s : lo_s;
              dir <= !dir;
            end
          end else begin
            if (t > hi_s) t <= hi_s;
            else if (t < lo_s) t <= lo_s;
          end
        end
        CMD_LOOP_FIN: begin
          if (loop_mode == MODE_WRAP) begin
            t <= lo_s + SumW'(wrap_r);
          end else begin
            t   <= pp_dir ? hi_s - SumW'(pp_over) : lo_s + SumW'(pp_over);
            dir <= !pp_dir;
          end
        end
        CMD_SCAN_START: begin
          // Ends of the table are settled at once, otherwise a linear scan.
          playhead  <= t[41:0];
          scan_addr <= inc ? AddrW'(1) : last - 1'b1;
          if (t >= tql) begin
            idx   <= last;
            found <= 1'b1;
          end else if (t <= tq0) begin
            idx   <= '0;
            found <= 1'b1;
          end
        end
        CMD_SCAN: begin
          if (inc) begin
            if (tqr > t) begin
              idx   <= scan_addr - 1'b1;
              found <= 1'b1;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end else begin
            if (tqr < t) begin
              idx   <= scan_addr + 1'b1;
              found <= 1'b1;
            end else begin
              scan_addr <= scan_addr - 1'b1;
            end
          end
        end
        CMD_RD_IDX: nxt <= nxt_calc;
        CMD_RD_NXT: ti  <= rd_data;
        CMD_INTERP: tn  <= rd_data;
        CMD_INTERP_START: q_neg <= (num < 0) != den[TimeW];
        CMD_EMIT: begin
          held_frame     <= idx;
          held_next      <= nxt;
          held_interp    <= v_sat;
          prev_frame     <= {1'b0, idx};
          done           <= 1'b1;
          frame_new      <= (prev_frame != {1'b0, idx});
          frame_index    <= idx;
          next_index     <= nxt;
          interp_index   <= v_sat;
          playhead_time  <= playhead[41] ? '0 : playhead[39:8];
          moving_forward <= dir;
        end
        CMD_EMIT_HELD: begin
          done           <= 1'b1;
          frame_index    <= held_frame;
          next_index     <= held_next;
          interp_index   <= held_interp;
          playhead_time  <= playhead[41] ? '0 : playhead[39:8];
          moving_forward <= dir;
        end
        default: ;
      endcase
    end
  end

  assign status.skip     = !run_enable || (entry_count == '0);
  assign status.need_div = need_div;
  assign status.found    = found;
  assign status.eq       = eq;
  assign status.div_done = div_done;
endmodule

// File: sv/timeline_playhead_loop_indexer_core.sv
// Channel   | Handshake      | Payload
// request   | start, busy    | op, elapsed_us, entry_index, entry_time
// result    | done (1 cycle) | frame_index, next_index, interp_index, frame_new,
//           |                | playhead_time, moving_forward
// config    | cfg_we         | cfg_index, cfg_data
//
// A table write stays idle and gives no result. A tick on a stopped or empty
// table answers from the skip state with the held result. A running tick reads
// the table ends, scales and adds the move, steps the loop, scans linearly for
// the frame (one memory read port) and interpolates, using up to two serial divisions.
// Reset is synchronous; results cannot be stalled and are shown for one cycle.
// Top level: controller plus datapath. Depends on tpli_pkg.
`timescale 1ns / 1ps
module timeline_playhead_loop_indexer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op,
  input  logic [19:0]                elapsed_us,
  input  logic [tpli_pkg::AddrW-1:0] entry_index,
  input  logic [tpli_pkg::TimeW-1:0] entry_time,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  output logic                       done,
  output logic [tpli_pkg::AddrW-1:0] frame_index,
  output logic [tpli_pkg::AddrW-1:0] next_index,
  output logic [17:0]                interp_index,
  output logic                       frame_new,
  output logic [tpli_pkg::TimeW-1:0] playhead_time,
  output logic                       moving_forward
);
  import tpli_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing.
  tpli_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage and arithmetic.
  tpli_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .elapsed_us     (elapsed_us),
    .entry_index    (entry_index),
    .entry_time     (entry_time),
    .done           (done),
    .frame_index    (frame_index),
    .next_index     (next_index),
    .interp_index   (interp_index),
    .frame_new      (frame_new),
    .playhead_time  (playhead_time),
    .moving_forward (moving_forward)
  );
endmodule

// File: sv/tpli_checker.sv
// Port-level checks on the playhead indexer, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module tpli_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic done,
  input logic frame_new
);
  // A result is shown for a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted tick keeps the block busy in the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !op) |=> busy)
    else $error("tick request did not make the block busy");

  // A table write completes at once and gives no result.
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op) |=> (!busy && !done))
    else $error("table write misbehaved");

  // The new-frame flag only appears with a result.
  a_new_with_done: assert property (@(posedge clk) disable iff (rst)
    frame_new |-> done)
    else $error("frame_new without a result");
endmodule

bind timeline_playhead_loop_indexer_core tpli_checker u_tpli_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .done      (done),
  .frame_new (frame_new)
);
